[rtl/core/b64d_pkg.sv]
package b64d_pkg;

    typedef logic [6:0] code_t;

    localparam code_t CODE_PAD = 7'h7F;
    localparam code_t CODE_BAD = 7'h7E;

    localparam int BurstMax   = 3;
    localparam int QueueDepth = 6;
    localparam int ReadyLimit = QueueDepth - BurstMax;
    localparam int CountWidth = $clog2(QueueDepth + 1);
    localparam int IndexWidth = $clog2(QueueDepth);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_done;
        logic       length_error;
    } result_t;

    typedef struct packed {
        logic [1:0]             count;
        result_t [BurstMax-1:0] res;
    } burst_t;

    function automatic code_t map_symbol(input logic [7:0] c);
        logic [7:0] d_upper;
        logic [7:0] d_lower;
        logic [7:0] d_digit;
        code_t      code;
        d_upper = c - 8'd65;
        d_lower = c - 8'd71;
        d_digit = c + 8'd4;
        priority if (c >= 8'h41 && c <= 8'h5A)
        begin
            code = d_upper[6:0];
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            code = d_lower[6:0];
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            code = d_digit[6:0];
        end
        else if (c == 8'h2B)
        begin
            code = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            code = 7'd63;
        end
        else if (c == 8'h3D)
        begin
            code = CODE_PAD;
        end
        else
        begin
            code = CODE_BAD;
        end
        return code;
    endfunction

endpackage

[rtl/core/b64d_if.sv]
interface b64d_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       message_end;

    modport source (output valid, output symbol, output message_end, input ready);
    modport sink   (input valid, input symbol, input message_end, output ready);
endinterface

interface b64d_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;
    logic       length_error;

    modport source (output valid, output data_byte, output byte_valid, output run_last,
                    output message_done, output length_error, input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input run_last,
                    input message_done, input length_error, output ready);
endinterface

[rtl/core/b64d_quad.sv]
module b64d_quad (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       symbol,
    input  logic             message_end,
    output b64d_pkg::burst_t burst
);
    import b64d_pkg::*;

    localparam logic [1:0] LastPos = 2'd3;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    code_t      held_reg [3];
    code_t      code;
    code_t      c0;
    code_t      c1;
    code_t      c2;
    logic       drop;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    always_comb
    begin
        code = map_symbol(symbol);
        c0   = held_reg[0];
        c1   = held_reg[1];
        c2   = held_reg[2];
        drop = c0[6] | c1[6] | (c2 == CODE_BAD) | (code == CODE_BAD);
        b0   = {c0[5:0], c1[5:4]};
        b1   = c2[6] ? 8'h00 : {c1[3:0], c2[5:2]};
        b2   = code[6] ? 8'h00 : {c2[1:0], code[5:0]};

        burst    = '0;
        pos_next = pos_reg;
        if (take)
        begin
            if (pos_reg != LastPos)
            begin
                pos_next = message_end ? 2'd0 : pos_reg + 2'd1;
                if (message_end)
                begin
                    burst.count  = 2'd1;
                    burst.res[0] = '{data_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                     message_done: 1'b1, length_error: 1'b1};
                end
            end
            else
            begin
                pos_next = 2'd0;
                if (drop)
                begin
                    if (message_end)
                    begin
                        burst.count  = 2'd1;
                        burst.res[0] = '{data_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
                                         message_done: 1'b1, length_error: 1'b0};
                    end
                end
                else
                begin
                    burst.count  = 2'd3;
                    burst.res[0] = '{data_byte: b0, byte_valid: 1'b1, run_last: 1'b0,
                                     message_done: 1'b0, length_error: 1'b0};
                    burst.res[1] = '{data_byte: b1, byte_valid: 1'b1, run_last: 1'b0,
                                     message_done: 1'b0, length_error: 1'b0};
                    burst.res[2] = '{data_byte: b2, byte_valid: 1'b1, run_last: 1'b1,
                                     message_done: message_end, length_error: 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // hold codes until the quad completes
    always_ff @(posedge clk)
    begin
        if (take && pos_reg != LastPos)
        begin
            held_reg[pos_reg] <= code;
        end
    end

endmodule

[rtl/core/b64d_result_queue.sv]
module b64d_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  b64d_pkg::burst_t  burst,
    output b64d_pkg::result_t head,
    output logic              head_valid,
    input  logic              head_ready,
    output logic              space_ok
);
    import b64d_pkg::*;

    result_t                 q_reg  [QueueDepth];
    result_t                 q_next [QueueDepth];
    logic [CountWidth-1:0]   count_reg;
    logic [CountWidth-1:0]   count_next;
    logic [CountWidth-1:0]   base;
    logic [CountWidth-1:0]   slot;
    logic                    pop;

    always_comb
    begin
        pop  = (count_reg != '0) && head_ready;
        base = count_reg - CountWidth'(pop);
        slot = base;
        for (int i = 0; i < QueueDepth; i++)
        begin
            q_next[i] = q_reg[i];
        end
        // advance on a transfer
        for (int i = 0; i < QueueDepth - 1; i++)
        begin
            if (pop)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int k = 0; k < BurstMax; k++)
        begin
            slot = base + CountWidth'(k);
            if (k < int'(burst.count))
            begin
                q_next[slot[IndexWidth-1:0]] = burst.res[k];
            end
        end
        count_next = base + CountWidth'(burst.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign head       = q_reg[0];
    assign head_valid = (count_reg != '0);
    assign space_ok   = (count_reg <= CountWidth'(ReadyLimit));

endmodule

[rtl/core/base64_stream_decoder_unit.sv]
// Base64 stream decoder.
// Channel sym takes one character per transfer, with message_end on the last
// character of a message. Channel dec gives decoded results: three bytes for
// each good quad, nothing for a dropped quad, and a byte-less marker result
// when a message ends on a dropped quad, or mid-quad with length_error set.
// Results are registered in the output queue and leave it from its head, one
// result per cycle while dec.ready is high.
// Throughput: one character per cycle while dec.ready is high. Results
// collect in a six-entry output queue; sym.ready stays high while at most
// three results are queued, so a full quad burst always fits.
// Stall: when dec.ready is low the head result holds and the queue fills;
// sym.ready drops once more than three results wait.
// Reset: the queue empties and the quad position returns to the first code;
// held codes are not cleared.
module base64_stream_decoder_unit (
    input logic       clk,
    input logic       rst_n,
    b64d_sym_if.sink  sym,
    b64d_res_if.source dec
);
    import b64d_pkg::*;

    burst_t  burst;
    result_t head;
    logic    space_ok;
    logic    head_valid;

    b64d_quad u_quad (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (sym.valid && sym.ready),
        .symbol      (sym.symbol),
        .message_end (sym.message_end),
        .burst       (burst)
    );

    b64d_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .head       (head),
        .head_valid (head_valid),
        .head_ready (dec.ready),
        .space_ok   (space_ok)
    );

    assign sym.ready        = space_ok;
    assign dec.valid        = head_valid;
    assign dec.data_byte    = head.data_byte;
    assign dec.byte_valid   = head.byte_valid;
    assign dec.run_last     = head.run_last;
    assign dec.message_done = head.message_done;
    assign dec.length_error = head.length_error;

endmodule

[rtl/core/b64d_checker.sv]
module b64d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sym_ready,
    input logic       dec_valid,
    input logic       dec_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       message_done,
    input logic       length_error
);

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dec_valid |-> sym_ready)
        else $error("input not ready with empty output");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !byte_valid |-> run_last && message_done && data_byte == 8'h00)
        else $error("byte-less result is not a message end marker");

    a_lerr_shape: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && length_error |-> !byte_valid)
        else $error("length error carries a byte");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |=> dec_valid && $stable(data_byte) && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sym_ready    (sym.ready),
    .dec_valid    (dec.valid),
    .dec_ready    (dec.ready),
    .data_byte    (dec.data_byte),
    .byte_valid   (dec.byte_valid),
    .run_last     (dec.run_last),
    .message_done (dec.message_done),
    .length_error (dec.length_error)
);
